// ===== rtl/fast_atan2_approximation_unit_assert.svh =====
// Assertion macros for the RTL.
`ifndef FAST_ATAN2_APPROXIMATION_UNIT_ASSERT_SVH
`define FAST_ATAN2_APPROXIMATION_UNIT_ASSERT_SVH

// Same-cycle implication.
`define FA2_ASSERT_IMPL(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// Next-cycle implication.
`define FA2_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`endif

// ===== rtl/fa2_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fa2_pkg
// Shared constants, flag struct and rounded pi helpers.
// ----------------------------------------------------------------------------
package fa2_pkg;
   localparam int COORD_BITS_DEF      = 16;
   localparam int ANGLE_FRAC_BITS_DEF = 13;
   localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;

   typedef struct packed {
      logic origin;
      logic steep;
      logic neg;
      logic xneg;
      logic yneg;
   } fa2_flags_type;

   function automatic logic [63:0] pi_round(input int frac);
      return (PI_Q60 + (64'd1 << (59 - frac))) >> (60 - frac);
   endfunction

   function automatic logic [63:0] half_pi_round(input int frac);
      return (PI_Q60 + (64'd1 << (60 - frac))) >> (61 - frac);
   endfunction
endpackage

// ===== rtl/fa2_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fa2_front
// Magnitudes, octant flags, products, and the scaled numerator / denominator.
// ----------------------------------------------------------------------------
module fa2_front #(
   parameter int W  = 16,
   parameter int RW = 2 * W + 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  logic signed [W-1:0]    coord_y,
   input  logic signed [W-1:0]    coord_x,
   output logic                   out_valid,
   output logic [RW-1:0]          num,
   output logic [RW-1:0]          den,
   output fa2_pkg::fa2_flags_type out_flags
);
   import fa2_pkg::*;

   logic [W-1:0] ax, ay;
   logic [W-1:0] big1_ff, small1_ff;
   logic [2*W-1:0] pbs2_ff, pbb2_ff, pss2_ff;
   logic [RW-1:0] pbs_e, pbb_e, pss_e;
   logic [RW-1:0] num3_ff, den3_ff;
   fa2_flags_type fl_in, fl1_ff, fl2_ff, fl3_ff;
   logic v1_ff, v2_ff, v3_ff;

   assign ax = coord_x[W-1] ? (~coord_x + 1'b1) : coord_x;
   assign ay = coord_y[W-1] ? (~coord_y + 1'b1) : coord_y;

   always_comb begin
      fl_in.origin = (coord_x == '0) && (coord_y == '0);
      fl_in.steep  = ay > ax;
      fl_in.neg    = (coord_y != '0) && (coord_x[W-1] != coord_y[W-1]);
      fl_in.xneg   = coord_x[W-1];
      fl_in.yneg   = coord_y[W-1];
   end

   assign pbs_e = RW'(pbs2_ff);
   assign pbb_e = RW'(pbb2_ff);
   assign pss_e = RW'(pss2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         big1_ff   <= fl_in.steep ? ay : ax;
         small1_ff <= fl_in.steep ? ax : ay;
         fl1_ff    <= fl_in;
         pbs2_ff   <= big1_ff * small1_ff;
         pbb2_ff   <= big1_ff * big1_ff;
         pss2_ff   <= small1_ff * small1_ff;
         fl2_ff    <= fl1_ff;
         // 25*p and 25*big^2 + 7*small^2 by shift-add
         num3_ff   <= (pbs_e << 4) + (pbs_e << 3) + pbs_e;
         den3_ff   <= (pbb_e << 4) + (pbb_e << 3) + pbb_e + (pss_e << 3) - pss_e;
         fl3_ff    <= fl2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign num       = num3_ff;
   assign den       = den3_ff;
   assign out_flags = fl3_ff;
endmodule

// ===== rtl/fa2_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fa2_cell
// One restoring division step; shifts one quotient bit into q.
// ----------------------------------------------------------------------------
module fa2_cell #(
   parameter int RW = 37,
   parameter int N  = 14
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  logic [RW-1:0]          in_rem,
   input  logic [RW-1:0]          in_den,
   input  logic [N-1:0]           in_q,
   input  fa2_pkg::fa2_flags_type in_flags,
   output logic                   out_valid,
   output logic [RW-1:0]          out_rem,
   output logic [RW-1:0]          out_den,
   output logic [N-1:0]           out_q,
   output fa2_pkg::fa2_flags_type out_flags
);
   import fa2_pkg::*;

   logic [RW:0] sh, diff;
   logic        ge;
   logic        valid_ff;
   logic [RW-1:0] rem_ff, den_ff;
   logic [N-1:0]  q_ff;
   fa2_flags_type flags_ff;

   assign sh   = {in_rem, 1'b0};
   assign ge   = sh >= {1'b0, in_den};
   assign diff = sh - {1'b0, in_den};

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (adv) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // remainder stays below den, so the top bit drops
         rem_ff   <= ge ? diff[RW-1:0] : sh[RW-1:0];
         den_ff   <= in_den;
         q_ff     <= {in_q[N-2:0], ge};
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_q     = q_ff;
   assign out_flags = flags_ff;
endmodule

// ===== rtl/fa2_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fa2_back
// Rounding, octant fold, sign and quadrant shift into the output register.
// ----------------------------------------------------------------------------
module fa2_back #(
   parameter int F = 13
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  logic [F:0]             in_q,
   input  fa2_pkg::fa2_flags_type in_flags,
   output logic                   out_valid,
   output logic signed [F+2:0]    angle
);
   import fa2_pkg::*;

   localparam int AW = F + 3;
   localparam logic signed [AW-1:0] PI_C   = AW'(pi_round(F));
   localparam logic signed [AW-1:0] HALF_C = AW'(half_pi_round(F));

   logic [F+1:0] qp;
   logic signed [AW-1:0] ratio, mag, sgn, angle_in;
   logic valid_ff;
   logic signed [AW-1:0] angle_ff;

   always_comb begin
      qp    = {1'b0, in_q} + 1'b1;
      ratio = AW'(qp[F+1:1]);
      mag   = in_flags.steep ? (HALF_C - ratio) : ratio;
      sgn   = in_flags.neg ? -mag : mag;
      if (in_flags.origin) angle_in = '0;
      else if (in_flags.xneg) angle_in = in_flags.yneg ? (sgn - PI_C) : (sgn + PI_C);
      else angle_in = sgn;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (adv) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) angle_ff <= angle_in;
   end

   assign out_valid = valid_ff;
   assign angle     = angle_ff;
endmodule

// ===== rtl/fast_atan2_approximation_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fast_atan2_approximation_unit
// Four-quadrant atan2 by the 0.28 rational form, quotient by a cell chain.
// ----------------------------------------------------------------------------
// channel | ports                          | dir
// req     | req_valid/ready, coord_y/x     | in
// rsp     | rsp_valid/ready, angle         | out
//
// One beat per cycle sustained while the output is not stalled; the pipe has
// 3 front stages, ANGLE_FRAC_BITS + 1 division cells and 1 output stage.
// Each division cell does one quotient bit.
// The whole pipe advances when the output register is empty or taken;
// a stalled output freezes every stage. Synchronous reset clears valids.
module fast_atan2_approximation_unit #(
   parameter int COORD_BITS      = fa2_pkg::COORD_BITS_DEF,
   parameter int ANGLE_FRAC_BITS = fa2_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [COORD_BITS-1:0]      req_coord_y,
   input  logic signed [COORD_BITS-1:0]      req_coord_x,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [ANGLE_FRAC_BITS+2:0] rsp_angle
);
   import fa2_pkg::*;
`include "fast_atan2_approximation_unit_assert.svh"

   localparam int W  = COORD_BITS;
   localparam int RW = 2 * W + 5;
   localparam int N  = ANGLE_FRAC_BITS + 1;
   localparam int AW = ANGLE_FRAC_BITS + 3;
   localparam logic signed [AW-1:0] PI_C = AW'(pi_round(ANGLE_FRAC_BITS));

   logic adv;
   logic          v_w   [0:N];
   logic [RW-1:0] rem_w [0:N];
   logic [RW-1:0] den_w [0:N];
   logic [N-1:0]  q_w   [0:N];
   fa2_flags_type fl_w  [0:N];

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;
   assign q_w[0]    = '0;

   fa2_front #(.W(W), .RW(RW)) u_front (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(req_valid), .coord_y(req_coord_y), .coord_x(req_coord_x),
      .out_valid(v_w[0]), .num(rem_w[0]), .den(den_w[0]), .out_flags(fl_w[0])
   );

   for (genvar i = 0; i < N; i++) begin : g_cell
      fa2_cell #(.RW(RW), .N(N)) u_cell (
         .clock(clock), .reset(reset), .adv(adv),
         .in_valid(v_w[i]), .in_rem(rem_w[i]), .in_den(den_w[i]),
         .in_q(q_w[i]), .in_flags(fl_w[i]),
         .out_valid(v_w[i+1]), .out_rem(rem_w[i+1]), .out_den(den_w[i+1]),
         .out_q(q_w[i+1]), .out_flags(fl_w[i+1])
      );
   end

   fa2_back #(.F(ANGLE_FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(v_w[N]), .in_q(q_w[N]), .in_flags(fl_w[N]),
      .out_valid(rsp_valid), .angle(rsp_angle)
   );

   `FA2_ASSERT_NEXT(a_last_to_out, clock, reset, v_w[N] && adv, rsp_valid)
   `FA2_ASSERT_IMPL(a_angle_range, clock, reset, rsp_valid,
      (rsp_angle <= PI_C) && (rsp_angle >= -PI_C))
   `FA2_ASSERT_NEXT(a_freeze_last, clock, reset, !adv, $stable(v_w[N]))
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the atan2 unit against an integer model of the 0.28 rational form,
// over directed axis, diagonal and extreme points and random points, with
// random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb;
   localparam int CB = fa2_pkg::COORD_BITS_DEF;
   localparam int FB = fa2_pkg::ANGLE_FRAC_BITS_DEF;
   localparam int AB = FB + 3;
   localparam int LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [CB-1:0] req_coord_y = '0;
   logic signed [CB-1:0] req_coord_x = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [AB-1:0] rsp_angle;

   fast_atan2_approximation_unit dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic signed [AB-1:0] angles_due[$];
   int   n_err = 0;
   int   n_beats = 0;
   int   n_sent = 0;
   int   cyc = 0;
   bit   hold_rsp = 1'b0;

   // Rounded magnitude of 25ab / (25*big^2 + 7*small^2), below one.
   function automatic longint unsigned ratio_q(longint unsigned a, longint unsigned b,
                                               longint unsigned big, longint unsigned sml);
      logic [127:0] num, den;
      longint unsigned q;
      num = 128'(a * b) * 25;
      den = 128'(big * big) * 25 + 128'(sml * sml) * 7;
      q = 0;
      for (int i = 0; i < FB + 1; i++) begin
         num = num << 1;
         q = q << 1;
         if (num >= den) begin
            num = num - den;
            q = q | 1;
         end
      end
      return (q + 1) >> 1;
   endfunction

   function automatic logic signed [AB-1:0] atan2_fixed(logic signed [CB-1:0] y,
                                                         logic signed [CB-1:0] x);
      longint pi_c, hpi_c, ang, mag;
      longint unsigned ax, ay;
      bit neg;
      pi_c = longint'((fa2_pkg::PI_Q60 + (64'd1 << (59 - FB))) >> (60 - FB));
      hpi_c = longint'((fa2_pkg::PI_Q60 + (64'd1 << (60 - FB))) >> (61 - FB));
      if (x == 0) begin
         ang = (y < 0) ? -hpi_c : (y > 0 ? hpi_c : 0);
      end else begin
         ax = (x < 0) ? -longint'(x) : longint'(x);
         ay = (y < 0) ? -longint'(y) : longint'(y);
         neg = (y != 0) && ((x < 0) != (y < 0));
         if (ay <= ax) mag = ratio_q(ax, ay, ax, ay);
         else mag = hpi_c - longint'(ratio_q(ax, ay, ay, ax));
         ang = neg ? -mag : mag;
         if (x < 0) ang += (y >= 0) ? pi_c : -pi_c;
      end
      return ang[AB-1:0];
   endfunction

   // Valid stays up across back-to-back beats; it drops only for a gap.
   task automatic send_point(int y, int x, int gap);
      logic signed [CB-1:0] ys, xs;
      ys = CB'(y);
      xs = CB'(x);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_coord_y <= ys;
      req_coord_x <= xs;
      angles_due.insert(angles_due.size(), atan2_fixed(ys, xs));
      do @(posedge clock); while (!req_ready);
      n_sent++;
   endtask

   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (cyc > LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         n_beats <= n_beats + 1;
         if (angles_due.size() == 0) begin
            $error("unexpected beat, angle %0d", rsp_angle);
            n_err <= n_err + 1;
         end else begin
            if (rsp_angle !== angles_due[0]) begin
               $error("angle: expected %0d, actual %0d", angles_due[0], rsp_angle);
               n_err <= n_err + 1;
            end
            void'(angles_due.pop_front());
         end
      end
   end

   // Receiver: random stalls, or a hard hold-off when requested.
   initial begin
      int w;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            @(posedge clock);
         end else begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (w > 0) begin
               rsp_ready <= 1'b0;
               repeat (w) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic int pick_gap();
      return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
   endfunction

   task automatic test_axes_and_corners();
      int mx, mn;
      mx = (1 << (CB - 1)) - 1;
      mn = -(1 << (CB - 1));
      send_point(0, 0, 0);
      send_point(1, 0, 0);
      send_point(-1, 0, 1);
      send_point(mx, 0, 0);
      send_point(mn, 0, 0);
      send_point(0, 5, 0);
      send_point(0, -5, 0);
      send_point(0, mn, 2);
      send_point(0, mx, 0);
      send_point(7, 7, 0);
      send_point(-7, 7, 0);
      send_point(7, -7, 0);
      send_point(-7, -7, 0);
      send_point(mn, mn, 0);
      send_point(mx, mn, 0);
      send_point(mn, mx, 0);
      send_point(mx, mx, 0);
      send_point(mx, 1, 0);
      send_point(1, mx, 0);
      send_point(mn, -1, 0);
      send_point(-1, mn, 0);
      send_point(-3, 2, 0);
   endtask

   task automatic test_random_points(int n);
      int y, x;
      for (int i = 0; i < n; i++) begin
         y = int'($urandom());
         x = int'($urandom());
         case ($urandom_range(0, 3))
            0: y = int'($urandom_range(0, 31)) - 16;
            1: x = int'($urandom_range(0, 31)) - 16;
            default: ;
         endcase
         send_point(y, x, pick_gap());
      end
   endtask

   task automatic test_output_stall();
      hold_rsp = 1'b1;
      fork
         test_random_points(40);
         begin
            repeat (200) @(posedge clock);
            hold_rsp = 1'b0;
         end
      join
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_axes_and_corners();
      test_random_points(180);
      test_output_stall();
      test_random_points(180);
      req_valid <= 1'b0;
      while (angles_due.size() != 0) @(posedge clock);
      repeat (3 * (FB + 5)) @(posedge clock);
      $display("Sent %0d points (axes, diagonals, extremes, random), checked %0d beats,",
               n_sent, n_beats);
      $display("with random gaps on both sides and one long output hold-off.");
      if (n_err == 0 && angles_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
